[rtl/bffa_pkg.sv]
// Shared types and constants for the bitmap first-free allocator.
// Used by bffa_ctrl, bffa_dp and the top level; no dependencies.
`default_nettype none

package bffa_pkg;

  // Bitmap geometry: the map is scanned one word per cycle
  localparam int MAP_BITS   = 128;
  localparam int WORD_BITS  = 16;
  localparam int NUM_WORDS  = MAP_BITS / WORD_BITS;
  localparam int WORD_IDX_W = $clog2(NUM_WORDS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int POS_W      = $clog2(MAP_BITS);

  // Field and register widths
  localparam int CFG_W = 8;
  localparam int NUM_W = 8;

  localparam logic [NUM_W-1:0] COUNT_MAX   = {NUM_W{1'b1}};
  localparam logic [CFG_W-1:0] TOTAL_RESET = CFG_W'(1 << (CFG_W - 1));
  localparam logic [CFG_W-1:0] FIRST_RESET = '0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_code_t;

  typedef enum logic {
    REG_TOTAL_COUNT = 1'b0,
    REG_FIRST_INDEX = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FREE,
    S_SCAN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic advance;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/bffa_dp.sv]
// Datapath of the allocator: bitmap words, config registers, scan logic,
// in-use count and the result register. Depends on bffa_pkg.
`default_nettype none

module bffa_dp
  import bffa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_cmd,
  input  wire logic [NUM_W-1:0]  in_number,
  input  wire dp_cmd_t           dp_cmd,
  output dp_stat_t               dp_stat,
  output logic [NUM_W-1:0]       out_granted,
  output logic [1:0]             out_status,
  output logic [NUM_W-1:0]       out_count
);

  logic [WORD_BITS-1:0]  map_r [NUM_WORDS];
  logic [CFG_W-1:0]      total_r;
  logic [CFG_W-1:0]      first_r;
  logic [NUM_W-1:0]      count_r;
  logic [NUM_W-1:0]      count_nxt;
  logic                  cmd_r;
  logic [NUM_W-1:0]      num_r;
  logic [WORD_IDX_W-1:0] word_idx_r;
  logic [NUM_W-1:0]      granted_r;
  logic [NUM_W-1:0]      granted_nxt;
  status_t               status_r;
  status_t               status_nxt;
  logic [NUM_W-1:0]      count_out_r;

  logic [CFG_W-1:0]      limit;
  logic [CFG_W-1:0]      limit_m1;
  logic                  range_empty;
  logic [WORD_IDX_W-1:0] last_word;
  logic [WORD_IDX_W-1:0] start_word;
  logic [WORD_BITS-1:0]  scan_word;
  logic [WORD_BITS-1:0]  avail;
  logic                  hit;
  logic [BIT_IDX_W-1:0]  hit_bit;
  logic [POS_W-1:0]      grant_pos;
  logic                  num_bad;
  logic [NUM_W-1:0]      num_m1;
  logic [NUM_W-1:0]      count_inc;
  logic [NUM_W-1:0]      count_dec;

  logic                  map_we;
  logic [WORD_IDX_W-1:0] map_waddr;
  logic [BIT_IDX_W-1:0]  map_wbit;
  logic                  map_wval;

  // Clamp the total to the map size and derive the scan window
  assign limit       = (total_r > CFG_W'(MAP_BITS)) ? CFG_W'(MAP_BITS) : total_r;
  assign limit_m1    = limit - CFG_W'(1);
  assign range_empty = (first_r >= limit);
  assign last_word   = limit_m1[POS_W-1:BIT_IDX_W];
  assign start_word  = first_r[POS_W-1:BIT_IDX_W];

  // Find clear bits of the current word inside the window
  assign scan_word = map_r[word_idx_r];

  always_comb begin
    logic [POS_W-1:0] pos;
    for (int j = 0; j < WORD_BITS; j++) begin
      pos      = {word_idx_r, BIT_IDX_W'(j)};
      avail[j] = !scan_word[j] && (CFG_W'(pos) >= first_r) && (CFG_W'(pos) < limit);
    end
  end

  // Lowest available bit wins
  always_comb begin
    hit_bit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        hit_bit = BIT_IDX_W'(j);
      end
    end
  end

  assign hit       = |avail;
  assign grant_pos = {word_idx_r, hit_bit};

  assign dp_stat.scan_done = range_empty || hit || (word_idx_r == last_word);

  // Free-number checks and saturating count steps
  assign num_bad   = (num_r == '0) || (CFG_W'(num_r) > limit);
  assign num_m1    = num_r - NUM_W'(1);
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + NUM_W'(1);
  assign count_dec = (count_r == '0) ? count_r : count_r - NUM_W'(1);

  // Resolve the command at commit time
  always_comb begin
    count_nxt   = count_r;
    granted_nxt = '0;
    status_nxt  = ST_OK;
    map_we      = 1'b0;
    map_waddr   = word_idx_r;
    map_wbit    = hit_bit;
    map_wval    = 1'b1;
    if (cmd_r == CMD_FREE) begin
      map_waddr = num_m1[POS_W-1:BIT_IDX_W];
      map_wbit  = num_m1[BIT_IDX_W-1:0];
      map_wval  = 1'b0;
      if (num_bad) begin
        status_nxt = ST_RANGE;
      end else begin
        map_we    = 1'b1;
        count_nxt = count_dec;
      end
    end else begin
      if (hit && !range_empty) begin
        map_we      = 1'b1;
        count_nxt   = count_inc;
        granted_nxt = NUM_W'(grant_pos) + NUM_W'(1);
      end else begin
        status_nxt = ST_FULL;
      end
    end
  end

  // Config registers, bitmap and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
      first_r <= FIRST_RESET;
      count_r <= '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        map_r[w] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_addr))
          REG_TOTAL_COUNT: total_r <= cfg_wdata;
          REG_FIRST_INDEX: first_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (dp_cmd.commit) begin
        count_r <= count_nxt;
        if (map_we) begin
          map_r[map_waddr][map_wbit] <= map_wval;
        end
      end
    end
  end

  // Latch the command word, step the scan, load the result register
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r      <= in_cmd;
      num_r      <= in_number;
      word_idx_r <= start_word;
    end else if (dp_cmd.advance) begin
      word_idx_r <= word_idx_r + WORD_IDX_W'(1);
    end
    if (dp_cmd.commit) begin
      granted_r   <= granted_nxt;
      status_r    <= status_nxt;
      count_out_r <= count_nxt;
    end
  end

  assign out_granted = granted_r;
  assign out_status  = status_r;
  assign out_count   = count_out_r;

endmodule

`default_nettype wire

[rtl/bffa_ctrl.sv]
// Controller of the allocator: command sequencing and the result-valid flag.
// Depends on bffa_pkg; drives bffa_dp through dp_cmd_t.
`default_nettype none

module bffa_ctrl
  import bffa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic     in_cmd,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output dp_cmd_t       dp_cmd,
  input  wire dp_stat_t dp_stat
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  // Result register can take a word when empty or being drained
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    dp_cmd         = '0;
    in_tready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = (in_cmd == CMD_FREE) ? S_FREE : S_SCAN;
        end
      end
      S_FREE: begin
        if (slot_free) begin
          dp_cmd.commit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!dp_stat.scan_done) begin
          dp_cmd.advance = 1'b1;
        end else if (slot_free) begin
          dp_cmd.commit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = dp_cmd.commit || (out_valid_r && !out_tready);
  end

  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  // Never overwrite a result that is still waiting
  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |-> (!out_valid_r || out_tready))
    else $error("commit while result register is occupied");

  // One command at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a command is in progress");

  // A new result only appears after a commit
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(dp_cmd.commit))
    else $error("result valid without commit");

  // Scan steps and loads are each exclusive with commit
  a_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_cmd.advance && dp_cmd.commit) && !(dp_cmd.load && dp_cmd.commit))
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

[rtl/bitmap_first_free_allocator.sv]
// Top level of the bitmap first-free allocator: stream ports, config port.
// Depends on bffa_pkg, bffa_ctrl and bffa_dp.
//
//   channel  direction  handshake           payload
//   in_      slave      in_tvalid/in_tready  tuser: cmd; tdata: item_number
//   out_     master     out_tvalid/out_tready tdata: granted, status, count
//   cfg_     write      cfg_wr_en            cfg_addr, cfg_wdata
//
// A free is accepted in S_IDLE and committed in S_FREE before the next accept. An
// allocate scans 1..8 bitmap words at 16 bits per cycle, starting at the
// word holding first_index; the word scan sets the rate.
// Reset clears the whole bitmap and the count at once; no clearing pass.
// One result waits in the output register while the next command runs; that
// command holds at its final step until the register is drained.
`default_nettype none

module bitmap_first_free_allocator
  import bffa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] item_number
  input  wire logic              in_tuser,   // [0] cmd
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [23:0]            out_tdata   // [7:0] granted_number, [9:8] status,
                                             // [17:10] in_use_count, [23:18] zero
);

  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  logic [NUM_W-1:0] granted;
  logic [1:0]       status;
  logic [NUM_W-1:0] count;

  bffa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  bffa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_cmd      (in_tuser),
    .in_number   (in_tdata[NUM_W-1:0]),
    .dp_cmd      (dp_cmd),
    .dp_stat     (dp_stat),
    .out_granted (granted),
    .out_status  (status),
    .out_count   (count)
  );

  // Pack the result word
  assign out_tdata = {6'b0, count, status, granted};

endmodule

`default_nettype wire

[bench/bffa_checker.sv]
// Checker for the bitmap first-free allocator: follows config writes and both
// stream channels, predicts each command's result and compares it on arrival.
// Depends on bffa_pkg for field widths, status, command and register codes.
`timescale 1ns / 1ps

module bffa_checker
  import bffa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_tvalid,
  input  wire logic              in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] item_number
  input  wire logic              in_tuser,   // [0] cmd
  input  wire logic              out_tvalid,
  input  wire logic              out_tready,
  input  wire logic [23:0]       out_tdata,  // [7:0] granted, [9:8] status,
                                             // [17:10] in_use_count, [23:18] zero
  output int unsigned            errors,
  output int unsigned            pending
);

  typedef struct packed {
    logic [NUM_W-1:0] granted;
    status_t          status;
    logic [NUM_W-1:0] in_use;
  } grant_result_t;

  // Shadow of the allocator state and its registers
  logic [MAP_BITS-1:0] used_bits;
  logic [NUM_W-1:0]    in_use_shadow;
  logic [CFG_W-1:0]    total_reg;
  logic [CFG_W-1:0]    first_reg;
  grant_result_t       results_due[$];

  initial begin
    used_bits     = '0;
    in_use_shadow = '0;
    total_reg     = TOTAL_RESET;
    first_reg     = FIRST_RESET;
    errors        = 0;
    pending       = 0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Apply one command to the shadow state and return the result it produces
  function automatic grant_result_t apply_command(cmd_code_t cmd, logic [NUM_W-1:0] num);
    grant_result_t r;
    int            limit;
    int            pos;
    bit            found;
    limit     = (int'(total_reg) > MAP_BITS) ? MAP_BITS : int'(total_reg);
    r.granted = '0;
    r.status  = ST_OK;
    found     = 1'b0;
    if (cmd == CMD_ALLOC) begin
      // first fit from the scan start, below the effective total
      r.status = ST_FULL;
      for (pos = int'(first_reg); pos < limit && !found; pos++) begin
        if (!used_bits[pos]) begin
          found          = 1'b1;
          used_bits[pos] = 1'b1;
          r.granted      = NUM_W'(pos + 1);
          r.status       = ST_OK;
          if (in_use_shadow != COUNT_MAX) in_use_shadow++;
        end
      end
    end else if (num == 0 || int'(num) > limit) begin
      r.status = ST_RANGE;
    end else begin
      // a double free leaves the bit clear but still drops the count
      used_bits[int'(num) - 1] = 1'b0;
      if (in_use_shadow != 0) in_use_shadow--;
    end
    r.in_use = in_use_shadow;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    grant_result_t want;
    if (rst_n) begin
      // the user must write registers only while the block is idle; the block does not enforce it
      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_addr))
          REG_TOTAL_COUNT: total_reg = cfg_wdata;
          REG_FIRST_INDEX: first_reg = cfg_wdata;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready)
        results_due.push_back(apply_command(cmd_code_t'(in_tuser), in_tdata));

      // compare each result word with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result word 0x%06h with no command pending", out_tdata));
        end else begin
          want = results_due.pop_front();
          if (out_tdata[7:0] !== want.granted)
            report_mismatch($sformatf("granted_number %0d, expected %0d",
                                      out_tdata[7:0], want.granted));
          if (out_tdata[9:8] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_tdata[9:8], want.status));
          if (out_tdata[17:10] !== want.in_use)
            report_mismatch($sformatf("in_use_count %0d, expected %0d",
                                      out_tdata[17:10], want.in_use));
          if (out_tdata[23:18] !== '0)
            report_mismatch($sformatf("padding bits 0x%02h, expected zero",
                                      out_tdata[23:18]));
        end
      end
      pending = results_due.size();
    end
  end

endmodule

[bench/bitmap_first_free_allocator_tb.sv]
// Testbench top for the bitmap first-free allocator: drives commands and
// config writes with random gaps and stalls, and gives the verdict.
// Depends on bffa_pkg, the allocator RTL and bffa_checker.
`timescale 1ns / 1ps

module bitmap_first_free_allocator_tb;
  import bffa_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_addr;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;   // [7:0] item_number
  logic              in_tuser;   // [0] cmd
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;  // [7:0] granted, [9:8] status, [17:10] count

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles;
  bit          in_steady;
  bit          out_steady;

  bitmap_first_free_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bffa_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls unless in a steady stretch
  initial begin : drain_side
    int unsigned stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (!out_steady) stall_left = pick_gap();
      end
    end
  end

  // Present one command word, hold it until accepted, then maybe idle
  task automatic issue_command(cmd_code_t cmd, logic [7:0] num);
    int unsigned gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = num;
    do @(posedge clk); while (!in_tready);
    gap = in_steady ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off the sender until every expected result word is back
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin : stimulus
    int          phase;
    int          n;
    int          items;
    int unsigned pct;
    int unsigned r;
    int unsigned eff;
    logic [7:0]  tot;
    logic [7:0]  fst;
    logic [7:0]  num;

    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_addr   = REG_TOTAL_COUNT;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_ALLOC;
    in_steady  = 1'b0;
    out_steady = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: range errors, double free on an empty map, first fit
    issue_command(CMD_FREE, 8'd0);
    issue_command(CMD_FREE, 8'd129);
    issue_command(CMD_FREE, 8'd255);
    issue_command(CMD_FREE, 8'd1);
    issue_command(CMD_ALLOC, 8'd0);
    issue_command(CMD_ALLOC, 8'd255);
    issue_command(CMD_ALLOC, 8'd77);
    issue_command(CMD_FREE, 8'd2);
    issue_command(CMD_ALLOC, 8'd0);
    issue_command(CMD_FREE, 8'd128);
    issue_command(CMD_FREE, 8'd128);
    wait_idle();

    // Small map with reserved low positions until full
    write_register(REG_TOTAL_COUNT, 8'd5);
    write_register(REG_FIRST_INDEX, 8'd2);
    issue_command(CMD_ALLOC, 8'd0);
    issue_command(CMD_ALLOC, 8'd0);
    issue_command(CMD_ALLOC, 8'd0);
    issue_command(CMD_FREE, 8'd6);
    issue_command(CMD_FREE, 8'd5);
    wait_idle();

    // Scan start at the total
    write_register(REG_FIRST_INDEX, 8'd5);
    issue_command(CMD_ALLOC, 8'd0);
    wait_idle();

    // Total above the map size, scan from the last position
    write_register(REG_TOTAL_COUNT, 8'd200);
    write_register(REG_FIRST_INDEX, 8'd127);
    issue_command(CMD_ALLOC, 8'd0);
    issue_command(CMD_ALLOC, 8'd0);
    issue_command(CMD_FREE, 8'd129);
    issue_command(CMD_FREE, 8'd128);
    wait_idle();

    // Empty map
    write_register(REG_TOTAL_COUNT, 8'd0);
    issue_command(CMD_FREE, 8'd1);
    issue_command(CMD_ALLOC, 8'd0);
    wait_idle();

    // Scan start far past the map
    write_register(REG_TOTAL_COUNT, 8'd128);
    write_register(REG_FIRST_INDEX, 8'd255);
    issue_command(CMD_ALLOC, 8'd0);
    wait_idle();

    // Random phases, each with its own settings and command mix
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin tot = 8'd128; fst = 8'd0;   pct = 75; end
        1: begin tot = 8'd16;  fst = 8'd3;   pct = 60; end
        2: begin tot = 8'd255; fst = 8'd120; pct = 80; end
        3: begin tot = 8'd1;   fst = 8'd0;   pct = 50; end
        4: begin tot = 8'd0;   fst = 8'd0;   pct = 50; end
        5: begin tot = 8'd64;  fst = 8'd128; pct = 50; end
        6: begin tot = 8'd128; fst = 8'd255; pct = 40; end
        7: begin
          tot = 8'($urandom_range(2, 127));
          fst = 8'($urandom_range(0, tot - 1));
          pct = 65;
        end
        8: begin tot = 8'd200; fst = 8'd100; pct = 70; end
        default: begin tot = 8'd128; fst = 8'd0; pct = 90; end
      endcase
      eff        = (tot > MAP_BITS) ? MAP_BITS : tot;
      items      = (phase >= 4 && phase <= 6) ? 30 : 109;
      in_steady  = (phase % 3 == 1);
      out_steady = (phase % 3 == 2);
      write_register(REG_TOTAL_COUNT, tot);
      write_register(REG_FIRST_INDEX, fst);

      for (n = 0; n < items; n++) begin
        r = $urandom_range(99);
        if (r < pct) begin
          issue_command(CMD_ALLOC, 8'($urandom_range(0, 255)));
        end else begin
          // mostly frees inside the map, some just outside, some anywhere
          r = $urandom_range(99);
          if (r < 85 && eff != 0)
            num = 8'($urandom_range(1, eff));
          else if (r < 95)
            num = ($urandom_range(1) != 0) ? 8'd0 : 8'($urandom_range(eff + 1, 255));
          else
            num = 8'($urandom_range(0, 255));
          issue_command(CMD_FREE, num);
        end
        if ($urandom_range(99) == 0) wait_idle();
      end
      wait_idle();
    end

    // Let the output register settle, then give the verdict
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bffa_pkg.sv
rtl/bffa_dp.sv
rtl/bffa_ctrl.sv
rtl/bitmap_first_free_allocator.sv
bench/bffa_checker.sv
bench/bitmap_first_free_allocator_tb.sv
